// File: rtl/slx_pkg.sv
// Shared types and constants of the script lexer.
// Holds the request record, the lexer mode encoding and the character codes.
// Depends on nothing.
package slx_pkg;

	localparam int SLX_POS_BITS = 16;

	localparam logic [4:0] K_POINT     = 5'd0;
	localparam logic [4:0] K_INT       = 5'd1;
	localparam logic [4:0] K_FLOAT     = 5'd2;
	localparam logic [4:0] K_WORD      = 5'd3;
	localparam logic [4:0] K_STRING    = 5'd4;
	localparam logic [4:0] K_EQ        = 5'd5;
	localparam logic [4:0] K_ASSIGN    = 5'd6;
	localparam logic [4:0] K_LE        = 5'd7;
	localparam logic [4:0] K_LT        = 5'd8;
	localparam logic [4:0] K_GE        = 5'd9;
	localparam logic [4:0] K_GT        = 5'd10;
	localparam logic [4:0] K_COMMA     = 5'd11;
	localparam logic [4:0] K_COLON     = 5'd12;
	localparam logic [4:0] K_SEMICOLON = 5'd13;
	localparam logic [4:0] K_LPAREN    = 5'd14;
	localparam logic [4:0] K_RPAREN    = 5'd15;
	localparam logic [4:0] K_LBRACKET  = 5'd16;
	localparam logic [4:0] K_RBRACKET  = 5'd17;
	localparam logic [4:0] K_LBRACE    = 5'd18;
	localparam logic [4:0] K_RBRACE    = 5'd19;
	localparam logic [4:0] K_NEWLINE   = 5'd20;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DQ       = 8'h22;
	localparam logic [7:0] CH_SQ       = 8'h27;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_DIGIT_LO = 8'd47;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_DIGIT_HI = 8'd58;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_EQ       = 8'h3D;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_UC_A     = 8'h41;
	localparam logic [7:0] CH_UC_Z     = 8'h5A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSL      = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_US       = 8'h5F;
	localparam logic [7:0] CH_LC_A     = 8'h61;
	localparam logic [7:0] CH_LC_F     = 8'h66;
	localparam logic [7:0] CH_LC_Z     = 8'h7A;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	typedef enum logic [11:0] {
		M_TOP        = 12'b0000_0000_0001,
		M_NUM        = 12'b0000_0000_0010,
		M_WORD       = 12'b0000_0000_0100,
		M_STR_DQ     = 12'b0000_0000_1000,
		M_STR_SQ     = 12'b0000_0001_0000,
		M_ESC_DQ     = 12'b0000_0010_0000,
		M_ESC_SQ     = 12'b0000_0100_0000,
		M_PEND_DOT   = 12'b0000_1000_0000,
		M_PEND_MINUS = 12'b0001_0000_0000,
		M_PEND_EQ    = 12'b0010_0000_0000,
		M_PEND_LT    = 12'b0100_0000_0000,
		M_PEND_GT    = 12'b1000_0000_0000
	} mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic        has_char;
		logic [7:0]  text_char;
		logic        token_end;
		logic        done_res;
		logic        error;
		logic [15:0] error_pos;
		logic        last;
	} res_t;

	localparam res_t RES_NONE = '0;

endpackage

// File: rtl/slx_step.sv
// Combinational step of the script lexer: one text byte and the lexer state
// give the next state and up to two requests.
// Depends on slx_pkg.
module slx_step #(
	parameter int POS_BITS = slx_pkg::SLX_POS_BITS
) (
	input  logic [7:0]          ch,
	input  slx_pkg::mode_t      mode,
	input  logic                dec,
	input  logic [POS_BITS-1:0] pos,
	input  logic [POS_BITS-1:0] ts,
	output logic [1:0]          n,
	output slx_pkg::res_t       r0,
	output slx_pkg::res_t       r1,
	output slx_pkg::mode_t      mode_nxt,
	output logic                dec_nxt,
	output logic [POS_BITS-1:0] pos_nxt,
	output logic [POS_BITS-1:0] ts_nxt
);
	import slx_pkg::*;

	typedef struct packed {
		mode_t               mode;
		logic                ts_we;
		logic [POS_BITS-1:0] ts;
		logic                dec_clr;
		logic                res_v;
		res_t                res;
	} start_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c > CH_DIGIT_LO) && (c < CH_DIGIT_HI);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c == CH_US) || is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
			((c >= CH_UC_A) && (c <= CH_UC_Z));
	endfunction

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
		return (p == '1) ? p : p + 1'b1;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic res_t mk_char(input logic [4:0] k, input logic [7:0] c,
		input logic e);
		res_t r;
		r = RES_NONE;
		r.kind = k;
		r.has_char = 1'b1;
		r.text_char = c;
		r.token_end = e;
		return r;
	endfunction

	function automatic res_t mk_end(input logic [4:0] k);
		res_t r;
		r = RES_NONE;
		r.kind = k;
		r.token_end = 1'b1;
		return r;
	endfunction

	function automatic res_t mk_err(input logic [POS_BITS-1:0] p);
		res_t r;
		r = RES_NONE;
		r.done_res = 1'b1;
		r.error = 1'b1;
		r.error_pos = sat16(p);
		return r;
	endfunction

	function automatic res_t mk_single(input logic [4:0] k, input logic [7:0] c);
		return mk_char(k, c, 1'b1);
	endfunction

	function automatic start_t start_tok(input logic [7:0] c, input logic [POS_BITS-1:0] p);
		start_t s;
		s.mode = M_TOP;
		s.ts_we = 1'b0;
		s.ts = p;
		s.dec_clr = 1'b0;
		s.res_v = 1'b0;
		s.res = RES_NONE;
		case (c)
			CH_NUL: begin
				s.res_v = 1'b1;
				if (p == '0) begin
					s.res = mk_err(p);
				end else begin
					s.res = RES_NONE;
					s.res.done_res = 1'b1;
				end
			end
			CH_SPACE: ;
			CH_DOT: begin
				s.mode = M_PEND_DOT;
				s.ts_we = 1'b1;
			end
			CH_MINUS: begin
				s.mode = M_PEND_MINUS;
				s.ts_we = 1'b1;
			end
			CH_DQ: begin
				s.mode = M_STR_DQ;
				s.ts_we = 1'b1;
				s.ts = sat_inc(p);
			end
			CH_SQ: begin
				s.mode = M_STR_SQ;
				s.ts_we = 1'b1;
				s.ts = sat_inc(p);
			end
			CH_EQ: s.mode = M_PEND_EQ;
			CH_LT: s.mode = M_PEND_LT;
			CH_GT: s.mode = M_PEND_GT;
			CH_COMMA: begin s.res_v = 1'b1; s.res = mk_single(K_COMMA, c); end
			CH_COLON: begin s.res_v = 1'b1; s.res = mk_single(K_COLON, c); end
			CH_SEMI: begin s.res_v = 1'b1; s.res = mk_single(K_SEMICOLON, c); end
			CH_LPAREN: begin s.res_v = 1'b1; s.res = mk_single(K_LPAREN, c); end
			CH_RPAREN: begin s.res_v = 1'b1; s.res = mk_single(K_RPAREN, c); end
			CH_LBRACKET: begin s.res_v = 1'b1; s.res = mk_single(K_LBRACKET, c); end
			CH_RBRACKET: begin s.res_v = 1'b1; s.res = mk_single(K_RBRACKET, c); end
			CH_LBRACE: begin s.res_v = 1'b1; s.res = mk_single(K_LBRACE, c); end
			CH_RBRACE: begin s.res_v = 1'b1; s.res = mk_single(K_RBRACE, c); end
			CH_NL: begin s.res_v = 1'b1; s.res = mk_single(K_NEWLINE, c); end
			default: begin
				s.res_v = 1'b1;
				if (is_digit(c)) begin
					s.mode = M_NUM;
					s.dec_clr = 1'b1;
					s.ts_we = 1'b1;
					s.res = mk_char(K_INT, c, 1'b0);
				end else if (is_word(c)) begin
					s.mode = M_WORD;
					s.ts_we = 1'b1;
					s.res = mk_char(K_WORD, c, 1'b0);
				end else begin
					s.res = mk_err(p);
				end
			end
		endcase
		return s;
	endfunction

	start_t     st;
	logic       use_st;
	logic       lead_v;
	res_t       lead;
	logic [7:0] quote;
	logic [7:0] op;
	logic [4:0] nk;
	logic [4:0] k_pair;
	logic [4:0] k_single;
	logic       dq;
	logic       fin;
	res_t       a;
	res_t       b;
	logic [1:0] cnt;

	always_comb begin
		st = start_tok(ch, pos);
		use_st = 1'b0;
		lead_v = 1'b0;
		lead = RES_NONE;
		a = RES_NONE;
		b = RES_NONE;
		cnt = 2'd0;
		mode_nxt = mode;
		dec_nxt = dec;
		ts_nxt = ts;
		pos_nxt = sat_inc(pos);
		dq = (mode == M_STR_DQ) || (mode == M_ESC_DQ);
		quote = dq ? CH_DQ : CH_SQ;
		nk = dec ? K_FLOAT : K_INT;
		op = (mode == M_PEND_EQ) ? CH_EQ : ((mode == M_PEND_LT) ? CH_LT : CH_GT);
		k_pair = (mode == M_PEND_EQ) ? K_EQ : ((mode == M_PEND_LT) ? K_LE : K_GE);
		k_single = (mode == M_PEND_EQ) ? K_ASSIGN : ((mode == M_PEND_LT) ? K_LT : K_GT);

		unique case (mode) inside
			M_NUM: begin
				if (ch == CH_DOT) begin
					cnt = 2'd1;
					if (dec) begin
						a = mk_err(ts);
					end else begin
						dec_nxt = 1'b1;
						a = mk_char(K_FLOAT, ch, 1'b0);
					end
				end else if ((ch == CH_MINUS) || is_digit(ch)) begin
					cnt = 2'd1;
					a = mk_char(nk, ch, 1'b0);
				end else if (ch == CH_LC_F) begin
					cnt = 2'd1;
					a = mk_end(nk);
					mode_nxt = M_TOP;
				end else begin
					lead_v = 1'b1;
					lead = mk_end(nk);
					use_st = 1'b1;
				end
			end
			M_WORD: begin
				if (is_word(ch)) begin
					cnt = 2'd1;
					a = mk_char(K_WORD, ch, 1'b0);
				end else begin
					lead_v = 1'b1;
					lead = mk_end(K_WORD);
					use_st = 1'b1;
				end
			end
			M_STR_DQ, M_STR_SQ: begin
				if (ch == quote) begin
					cnt = 2'd1;
					a = mk_end(K_STRING);
					mode_nxt = M_TOP;
				end else if (ch == CH_BSL) begin
					mode_nxt = dq ? M_ESC_DQ : M_ESC_SQ;
				end else if (ch == CH_NUL) begin
					cnt = 2'd1;
					a = mk_err(ts);
				end else begin
					cnt = 2'd1;
					a = mk_char(K_STRING, ch, 1'b0);
				end
			end
			M_ESC_DQ, M_ESC_SQ: begin
				if (ch == quote) begin
					cnt = 2'd1;
					a = mk_char(K_STRING, ch, 1'b0);
					mode_nxt = dq ? M_STR_DQ : M_STR_SQ;
				end else if (ch == CH_BSL) begin
					cnt = 2'd1;
					a = mk_char(K_STRING, CH_BSL, 1'b0);
				end else if (ch == CH_NUL) begin
					cnt = 2'd1;
					a = mk_err(ts);
				end else begin
					cnt = 2'd2;
					a = mk_char(K_STRING, CH_BSL, 1'b0);
					b = mk_char(K_STRING, ch, 1'b0);
					mode_nxt = dq ? M_STR_DQ : M_STR_SQ;
				end
			end
			M_PEND_DOT: begin
				if (is_digit(ch)) begin
					cnt = 2'd2;
					a = mk_char(K_FLOAT, CH_DOT, 1'b0);
					b = mk_char(K_FLOAT, ch, 1'b0);
					mode_nxt = M_NUM;
					dec_nxt = 1'b1;
				end else begin
					lead_v = 1'b1;
					lead = mk_char(K_POINT, CH_DOT, 1'b1);
					use_st = 1'b1;
				end
			end
			M_PEND_MINUS: begin
				if (is_digit(ch)) begin
					cnt = 2'd2;
					a = mk_char(K_INT, CH_MINUS, 1'b0);
					b = mk_char(K_INT, ch, 1'b0);
					mode_nxt = M_NUM;
					dec_nxt = 1'b0;
				end else if (ch == CH_DOT) begin
					cnt = 2'd2;
					a = mk_char(K_FLOAT, CH_MINUS, 1'b0);
					b = mk_char(K_FLOAT, ch, 1'b0);
					mode_nxt = M_NUM;
					dec_nxt = 1'b1;
				end else begin
					cnt = 2'd1;
					a = mk_err(ts);
				end
			end
			M_PEND_EQ, M_PEND_LT, M_PEND_GT: begin
				if (ch == CH_EQ) begin
					cnt = 2'd2;
					a = mk_char(k_pair, op, 1'b0);
					b = mk_char(k_pair, CH_EQ, 1'b1);
					mode_nxt = M_TOP;
				end else begin
					lead_v = 1'b1;
					lead = mk_char(k_single, op, 1'b1);
					use_st = 1'b1;
				end
			end
			default: use_st = 1'b1;
		endcase

		if (use_st) begin
			mode_nxt = st.mode;
			if (st.ts_we) begin
				ts_nxt = st.ts;
			end
			if (st.dec_clr) begin
				dec_nxt = 1'b0;
			end
			if (lead_v) begin
				a = lead;
				b = st.res;
				cnt = st.res_v ? 2'd2 : 2'd1;
			end else begin
				a = st.res;
				cnt = st.res_v ? 2'd1 : 2'd0;
			end
		end

		a.last = (cnt == 2'd1);
		b.last = (cnt == 2'd2);
		fin = ((cnt != 2'd0) && a.done_res) || ((cnt == 2'd2) && b.done_res);
		if (fin) begin
			mode_nxt = M_TOP;
			dec_nxt = 1'b0;
			pos_nxt = '0;
			ts_nxt = '0;
		end
		n = cnt;
		r0 = a;
		r1 = b;
	end

endmodule

// File: rtl/slx_outq.sv
// Two-entry result queue of the script lexer; takes up to two requests per
// cycle and hands one out per cycle to the output channel unless it stalls.
// Depends on slx_pkg.
module slx_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  slx_pkg::res_t r0,
	input  slx_pkg::res_t r1,
	input  logic          out_stall,
	output logic          out_valid,
	output slx_pkg::res_t head,
	output logic [1:0]    space
);
	import slx_pkg::*;

	res_t       q_q [2];
	logic [1:0] cnt_q;
	res_t       nq [2];
	logic [1:0] ncnt;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign head = q_q[0];
	assign space = 2'd2 - cnt_q + {1'b0, pop};

	always_comb begin
		nq = q_q;
		ncnt = cnt_q;
		if (pop) begin
			nq[0] = q_q[1];
			ncnt = cnt_q - 2'd1;
		end
		case (push_n)
			2'd1: nq[ncnt[0]] = r0;
			2'd2: begin
				nq[0] = r0;
				nq[1] = r1;
			end
			default: ;
		endcase
		ncnt = ncnt + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= ncnt;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= nq;
	end

endmodule

// File: rtl/script_lexer.sv
// Top level of the script lexer: input register, lexer state and result queue.
// Depends on slx_pkg, slx_step and slx_outq.
//
// The lexer takes one text byte per cycle while in_stall is low and answers
// each byte with zero, one or two requests on the output channel; a byte waits
// in the input register until its requests fit into the registered result
// queue. Bytes giving one request or none sustain one byte per cycle while the
// output does not stall; the two requests of a byte that gives two are offered
// one after the other, as the two-entry result queue drains one request per
// cycle. Byte 0 ends a text with a done or error request, then a new text starts.
module script_lexer #(
	parameter int POS_BITS = slx_pkg::SLX_POS_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  kind,
	output logic        has_char,
	output logic [7:0]  text_char,
	output logic        token_end,
	output logic        done_res,
	output logic        error,
	output logic [15:0] error_pos,
	output logic        last
);
	import slx_pkg::*;

	logic                valid_s1;
	logic [7:0]          ch_s1;
	mode_t               mode_q;
	logic                dec_q;
	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] ts_q;

	logic [1:0]          n;
	res_t                r0;
	res_t                r1;
	mode_t               mode_nxt;
	logic                dec_nxt;
	logic [POS_BITS-1:0] pos_nxt;
	logic [POS_BITS-1:0] ts_nxt;
	logic [1:0]          space;
	logic                fire;
	logic                take;
	res_t                head;

	slx_step #(.POS_BITS(POS_BITS)) u_step (
		.ch       (ch_s1),
		.mode     (mode_q),
		.dec      (dec_q),
		.pos      (pos_q),
		.ts       (ts_q),
		.n        (n),
		.r0       (r0),
		.r1       (r1),
		.mode_nxt (mode_nxt),
		.dec_nxt  (dec_nxt),
		.pos_nxt  (pos_nxt),
		.ts_nxt   (ts_nxt)
	);

	assign fire = valid_s1 && (n <= space);
	assign in_stall = valid_s1 && !fire;
	assign take = in_valid && !in_stall;

	slx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? n : 2'd0),
		.r0        (r0),
		.r1        (r1),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.space     (space)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= M_TOP;
			dec_q <= 1'b0;
			pos_q <= '0;
			ts_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				mode_q <= mode_nxt;
				dec_q <= dec_nxt;
				pos_q <= pos_nxt;
				ts_q <= ts_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1 <= ch;
		end
	end

	assign kind = head.kind;
	assign has_char = head.has_char;
	assign text_char = head.text_char;
	assign token_end = head.token_end;
	assign done_res = head.done_res;
	assign error = head.error;
	assign error_pos = head.error_pos;
	assign last = head.last;

endmodule

// File: rtl/slx_checker.sv
// Port checker of the script lexer, bound to the top level.
// Depends on the port list of script_lexer only.
module slx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  ch,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  kind,
	input logic        has_char,
	input logic [7:0]  text_char,
	input logic        token_end,
	input logic        done_res,
	input logic        error,
	input logic [15:0] error_pos,
	input logic        last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(ch))
		else $error("stalled input request changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(text_char))
		else $error("stalled request changed");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last && !has_char && !token_end && kind == 5'd0)
		else $error("final request is malformed");

	a_error_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> error_pos == 16'd0)
		else $error("error position without error");

	a_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> text_char == 8'd0 && (!error || done_res))
		else $error("text byte without has_char");

endmodule

bind script_lexer slx_checker u_slx_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for script_lexer: drives text bytes and checks every output request.
// A lexer model inside the testbench predicts each request as its byte is taken.
// Depends on slx_pkg and script_lexer.
module tb_top;
	import slx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          HOLD_LEN    = 200;
	localparam logic [4:0]  KIND_NONE   = K_POINT;
	localparam logic [15:0] POS_TOP     = 16'hFFFF;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  ch        = CH_NUL;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [4:0]  kind;
	logic        has_char;
	logic [7:0]  text_char;
	logic        token_end;
	logic        done_res;
	logic        error;
	logic [15:0] error_pos;
	logic        last;

	logic [7:0]  bytes_todo[$];
	res_t        lexemes_due[$];
	res_t        step_q[$];
	res_t        seen;
	res_t        want;
	bit          step_fin;
	bit          step_err;

	mode_t       lx_mode = M_TOP;
	bit          lx_dec = 1'b0;
	logic [15:0] lx_pos = '0;
	logic [15:0] lx_tok = '0;

	int          send_idle = 25;
	int          recv_idle = 49;
	int          bytes_taken = 0;
	int          hold_at = 0;
	bit          hold_armed = 1'b0;
	bit          hold_fired = 1'b0;
	int          hold_left = 0;
	int          faults = 0;
	int          requests_seen = 0;
	int          texts_done = 0;
	int          texts_failed = 0;
	int unsigned cycle_cnt = 0;

	script_lexer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.has_char  (has_char),
		.text_char (text_char),
		.token_end (token_end),
		.done_res  (done_res),
		.error     (error),
		.error_pos (error_pos),
		.last      (last)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sat_next(logic [15:0] p);
		return (p == POS_TOP) ? p : p + 16'd1;
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c > CH_DIGIT_LO && c < CH_DIGIT_HI;
	endfunction

	function automatic bit is_wordc(logic [7:0] c);
		return c == CH_US || is_dig(c) || (c >= CH_LC_A && c <= CH_LC_Z)
			|| (c >= CH_UC_A && c <= CH_UC_Z);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		bytes_todo.insert(bytes_todo.size(), b);
	endfunction

	function automatic void put(logic [4:0] k, bit has, logic [7:0] c, bit te, bit dn,
		bit er, logic [15:0] ep);
		res_t r;
		if (step_q.size() < 2) begin
			r = RES_NONE;
			r.kind = k;
			r.has_char = has;
			r.text_char = has ? c : CH_NUL;
			r.token_end = te;
			r.done_res = dn;
			r.error = er;
			r.error_pos = ep;
			step_q.insert(step_q.size(), r);
			if (dn)
				step_fin = 1'b1;
			if (er)
				step_err = 1'b1;
		end
	endfunction

	function automatic void put_char(logic [4:0] k, logic [7:0] c, bit te);
		put(k, 1'b1, c, te, 1'b0, 1'b0, '0);
	endfunction

	function automatic void put_close(logic [4:0] k);
		put(k, 1'b0, CH_NUL, 1'b1, 1'b0, 1'b0, '0);
	endfunction

	function automatic void put_fail(logic [15:0] p);
		put(KIND_NONE, 1'b0, CH_NUL, 1'b0, 1'b1, 1'b1, p);
	endfunction

	function automatic void open_token(logic [7:0] c, logic [15:0] pos);
		lx_mode = M_TOP;
		case (c)
			CH_NUL: begin
				if (pos == 0)
					put_fail('0);
				else
					put(KIND_NONE, 1'b0, CH_NUL, 1'b0, 1'b1, 1'b0, '0);
			end
			CH_SPACE: ;
			CH_DOT: begin
				lx_mode = M_PEND_DOT;
				lx_tok = pos;
			end
			CH_MINUS: begin
				lx_mode = M_PEND_MINUS;
				lx_tok = pos;
			end
			CH_DQ: begin
				lx_mode = M_STR_DQ;
				lx_tok = sat_next(pos);
			end
			CH_SQ: begin
				lx_mode = M_STR_SQ;
				lx_tok = sat_next(pos);
			end
			CH_EQ: lx_mode = M_PEND_EQ;
			CH_LT: lx_mode = M_PEND_LT;
			CH_GT: lx_mode = M_PEND_GT;
			CH_COMMA: put_char(K_COMMA, c, 1'b1);
			CH_COLON: put_char(K_COLON, c, 1'b1);
			CH_SEMI: put_char(K_SEMICOLON, c, 1'b1);
			CH_LPAREN: put_char(K_LPAREN, c, 1'b1);
			CH_RPAREN: put_char(K_RPAREN, c, 1'b1);
			CH_LBRACKET: put_char(K_LBRACKET, c, 1'b1);
			CH_RBRACKET: put_char(K_RBRACKET, c, 1'b1);
			CH_LBRACE: put_char(K_LBRACE, c, 1'b1);
			CH_RBRACE: put_char(K_RBRACE, c, 1'b1);
			CH_NL: put_char(K_NEWLINE, c, 1'b1);
			default: begin
				if (is_dig(c)) begin
					lx_mode = M_NUM;
					lx_dec = 1'b0;
					lx_tok = pos;
					put_char(K_INT, c, 1'b0);
				end else if (is_wordc(c)) begin
					lx_mode = M_WORD;
					lx_tok = pos;
					put_char(K_WORD, c, 1'b0);
				end else begin
					put_fail(pos);
				end
			end
		endcase
	endfunction

	function automatic void resolve_op(logic [7:0] c, logic [15:0] pos, logic [7:0] op,
		logic [4:0] k_pair, logic [4:0] k_single);
		if (c == CH_EQ) begin
			put_char(k_pair, op, 1'b0);
			put_char(k_pair, CH_EQ, 1'b1);
			lx_mode = M_TOP;
		end else begin
			put_char(k_single, op, 1'b1);
			open_token(c, pos);
		end
	endfunction

	function automatic void string_byte(logic [7:0] c, logic [7:0] quote, mode_t esc_mode);
		if (c == quote) begin
			put_close(K_STRING);
			lx_mode = M_TOP;
		end else if (c == CH_BSL) begin
			lx_mode = esc_mode;
		end else if (c == CH_NUL) begin
			put_fail(lx_tok);
		end else begin
			put_char(K_STRING, c, 1'b0);
		end
	endfunction

	function automatic void escape_byte(logic [7:0] c, logic [7:0] quote, mode_t str_mode);
		if (c == quote) begin
			put_char(K_STRING, c, 1'b0);
			lx_mode = str_mode;
		end else if (c == CH_BSL) begin
			put_char(K_STRING, CH_BSL, 1'b0);
		end else if (c == CH_NUL) begin
			put_fail(lx_tok);
		end else begin
			put_char(K_STRING, CH_BSL, 1'b0);
			put_char(K_STRING, c, 1'b0);
			lx_mode = str_mode;
		end
	endfunction

	function automatic void lex_byte(logic [7:0] c);
		logic [15:0] pos;
		logic [4:0]  nk;
		step_q.delete();
		step_fin = 1'b0;
		step_err = 1'b0;
		pos = lx_pos;
		lx_pos = sat_next(pos);
		case (lx_mode)
			M_NUM: begin
				nk = lx_dec ? K_FLOAT : K_INT;
				if (c == CH_DOT) begin
					if (lx_dec) begin
						put_fail(lx_tok);
					end else begin
						lx_dec = 1'b1;
						put_char(K_FLOAT, c, 1'b0);
					end
				end else if (c == CH_MINUS || is_dig(c)) begin
					put_char(nk, c, 1'b0);
				end else if (c == CH_LC_F) begin
					put_close(nk);
					lx_mode = M_TOP;
				end else begin
					put_close(nk);
					open_token(c, pos);
				end
			end
			M_WORD: begin
				if (is_wordc(c)) begin
					put_char(K_WORD, c, 1'b0);
				end else begin
					put_close(K_WORD);
					open_token(c, pos);
				end
			end
			M_STR_DQ: string_byte(c, CH_DQ, M_ESC_DQ);
			M_STR_SQ: string_byte(c, CH_SQ, M_ESC_SQ);
			M_ESC_DQ: escape_byte(c, CH_DQ, M_STR_DQ);
			M_ESC_SQ: escape_byte(c, CH_SQ, M_STR_SQ);
			M_PEND_DOT: begin
				if (is_dig(c)) begin
					lx_mode = M_NUM;
					lx_dec = 1'b1;
					put_char(K_FLOAT, CH_DOT, 1'b0);
					put_char(K_FLOAT, c, 1'b0);
				end else begin
					put_char(K_POINT, CH_DOT, 1'b1);
					open_token(c, pos);
				end
			end
			M_PEND_MINUS: begin
				if (is_dig(c)) begin
					lx_mode = M_NUM;
					lx_dec = 1'b0;
					put_char(K_INT, CH_MINUS, 1'b0);
					put_char(K_INT, c, 1'b0);
				end else if (c == CH_DOT) begin
					lx_mode = M_NUM;
					lx_dec = 1'b1;
					put_char(K_FLOAT, CH_MINUS, 1'b0);
					put_char(K_FLOAT, c, 1'b0);
				end else begin
					put_fail(lx_tok);
				end
			end
			M_PEND_EQ: resolve_op(c, pos, CH_EQ, K_EQ, K_ASSIGN);
			M_PEND_LT: resolve_op(c, pos, CH_LT, K_LE, K_LT);
			M_PEND_GT: resolve_op(c, pos, CH_GT, K_GE, K_GT);
			default: open_token(c, pos);
		endcase
		if (step_q.size() != 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			lexemes_due.insert(lexemes_due.size(), step_q[i]);
		if (step_fin) begin
			texts_done++;
			if (step_err)
				texts_failed++;
			lx_mode = M_TOP;
			lx_dec = 1'b0;
			lx_pos = '0;
			lx_tok = '0;
		end
	endfunction

	function automatic string fmt_res(res_t r);
		return $sformatf("kind %0d char %0d/%02h end %0d done %0d err %0d pos %0d last %0d",
			r.kind, r.has_char, r.text_char, r.token_end, r.done_res, r.error,
			r.error_pos, r.last);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_DIGIT_LO + 8'($urandom_range(1, 10));
	endfunction

	function automatic logic [7:0] rand_letter();
		int n;
		n = $urandom_range(0, 52);
		if (n < 26)
			return CH_LC_A + 8'(n);
		else if (n < 52)
			return CH_UC_A + 8'(n - 26);
		return CH_US;
	endfunction

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_text();
		int         n_tok;
		logic [7:0] b;
		logic [7:0] quote;
		if ($urandom_range(0, 19) == 0) begin
			add_byte(CH_NUL);
			return;
		end
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			case ($urandom_range(0, 6))
				0: begin
					repeat ($urandom_range(1, 4))
						add_byte(rand_digit());
					if ($urandom_range(0, 3) == 0) begin
						add_byte(CH_MINUS);
						add_byte(rand_digit());
					end
					if ($urandom_range(0, 3) == 0)
						add_byte(CH_LC_F);
				end
				1: begin
					if ($urandom_range(0, 2) == 0)
						add_byte(CH_MINUS);
					if ($urandom_range(0, 3) != 0)
						repeat ($urandom_range(1, 3))
							add_byte(rand_digit());
					add_byte(CH_DOT);
					repeat ($urandom_range(1, 3))
						add_byte(rand_digit());
					if ($urandom_range(0, 3) == 0)
						add_byte(CH_LC_F);
				end
				2: begin
					add_byte(rand_letter());
					repeat ($urandom_range(0, 5))
						add_byte(($urandom_range(0, 3) == 0) ?
							rand_digit() : rand_letter());
				end
				3: begin
					quote = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
					add_byte(quote);
					repeat ($urandom_range(0, 6)) begin
						b = 8'($urandom_range(1, 255));
						if (b == quote || $urandom_range(0, 5) == 0)
							add_byte(CH_BSL);
						if (b == CH_BSL)
							b = rand_letter();
						add_byte(b);
					end
					add_byte(quote);
				end
				4: begin
					case ($urandom_range(0, 2))
						0: add_byte(CH_EQ);
						1: add_byte(CH_LT);
						default: add_byte(CH_GT);
					endcase
					if ($urandom_range(0, 1))
						add_byte(CH_EQ);
				end
				5: begin
					case ($urandom_range(0, 9))
						0: add_byte(CH_COMMA);
						1: add_byte(CH_COLON);
						2: add_byte(CH_SEMI);
						3: add_byte(CH_LPAREN);
						4: add_byte(CH_RPAREN);
						5: add_byte(CH_LBRACKET);
						6: add_byte(CH_RBRACKET);
						7: add_byte(CH_LBRACE);
						8: add_byte(CH_RBRACE);
						default: add_byte(CH_NL);
					endcase
				end
				default: add_byte(CH_DOT);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: add_byte(CH_SPACE);
				7: add_byte(CH_NL);
				8: add_byte(8'($urandom_range(1, 255)));
				default: ;
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			add_byte($urandom_range(0, 1) ? CH_DQ : CH_SQ);
			if ($urandom_range(0, 1))
				add_byte(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 1))
				add_byte(CH_BSL);
		end
		add_byte(CH_NUL);
	endtask

	task automatic wait_drained();
		while (bytes_todo.size() != 0 || in_valid || lexemes_due.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= CH_NUL;
		end else begin
			if (in_valid && !in_stall) begin
				lex_byte(ch);
				bytes_taken <= bytes_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (bytes_todo.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					ch <= bytes_todo.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_fired <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_fired && bytes_taken >= hold_at) begin
			hold_left <= HOLD_LEN;
			hold_fired <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = RES_NONE;
				seen.kind = kind;
				seen.has_char = has_char;
				seen.text_char = text_char;
				seen.token_end = token_end;
				seen.done_res = done_res;
				seen.error = error;
				seen.error_pos = error_pos;
				seen.last = last;
				requests_seen++;
				if (lexemes_due.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("Unexpected request: %s", fmt_res(seen));
				end else begin
					want = lexemes_due.pop_front();
					if (seen.kind !== want.kind || seen.has_char !== want.has_char
						|| seen.text_char !== want.text_char
						|| seen.token_end !== want.token_end
						|| seen.done_res !== want.done_res || seen.error !== want.error
						|| seen.error_pos !== want.error_pos || seen.last !== want.last) begin
						faults++;
						if (faults <= 10)
							$display("Mismatch: expected %s, got %s", fmt_res(want),
								fmt_res(seen));
					end
				end
			end
			out_stall <= hold_left != 0 || $urandom_range(0, 99) < recv_idle;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycle_cnt);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		add_byte(CH_NUL);
		push_str("x=-1.5f<=.");
		add_byte(CH_NUL);
		push_str("\"a\\\"\\b");
		add_byte(CH_NUL);
		push_str("1..");
		push_str("-;");
		push_str("'\\");
		add_byte(CH_NUL);
		add_byte(8'hFF);
		while (bytes_todo.size() < 220)
			add_text();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		send_idle = 49;
		recv_idle = 25;
		while (bytes_todo.size() < 200)
			add_text();
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		hold_at = bytes_taken + 10;
		hold_armed = 1'b1;
		while (bytes_todo.size() < 150)
			add_text();
		add_byte(CH_DQ);
		add_byte(CH_LC_A);
		add_byte(CH_NUL);
		wait_drained();

		repeat (20) @(posedge clk);
		if (lexemes_due.size() != 0) begin
			faults += lexemes_due.size();
			$display("%0d expected requests never arrived.", lexemes_due.size());
		end
		$display("Lexed %0d bytes as %0d texts, %0d stopped by a lexing error; %0d requests seen.",
			bytes_taken, texts_done, texts_failed, requests_seen);
		$display("Directed corner cases, random and noisy texts and a %0d-cycle output hold %s",
			HOLD_LEN, "with full input back-pressure were covered.");
		if (faults == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
